[rtl/serpentine_error_diffusion_rgb_defines.svh]
// Assertion macros for the serpentine error diffusion block.
// Used by the top level; no other dependencies.
`ifndef SERPENTINE_ERROR_DIFFUSION_RGB_DEFINES_SVH
`define SERPENTINE_ERROR_DIFFUSION_RGB_DEFINES_SVH

`ifndef SYNTH
`define SEDRGB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sedrgb assertion failed");
`define SEDRGB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sedrgb implication failed");
`else
`define SEDRGB_ASSERT(label, clk, rst_n, prop)
`define SEDRGB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/sedrgb_pkg.sv]
// Shared constants, types and the share function for the error diffusion block.
// No dependencies.
`timescale 1ns / 1ps

package sedrgb_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int LW_W      = 11;
	localparam int FH_W      = 16;
	localparam int PIX_W     = 8;
	localparam int NUM_CH    = 3;
	localparam int FRAC_BITS = 4;
	localparam int ERR_W     = 14;
	localparam int ACC_W     = 16;

	localparam logic signed [ACC_W-1:0] FULL_SCALE = ACC_W'(255 << FRAC_BITS);
	localparam logic signed [ACC_W-1:0] HALF_SCALE = ACC_W'(255 << (FRAC_BITS - 1));

	localparam logic [3:0] W_AHEAD  = 4'd7;
	localparam logic [3:0] W_BELOW  = 4'd5;
	localparam logic [3:0] W_BEHIND = 4'd3;
	localparam logic [3:0] W_DIAG   = 4'd1;

	localparam logic [LW_W-1:0] MAX_WIDTH_V = LW_W'(MAX_WIDTH);

	typedef enum logic {
		REG_LINE_WIDTH   = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef logic [NUM_CH*ERR_W-1:0] err_line_t;

	typedef struct packed {
		logic has_ahead;
		logic last_row;
	} chan_ctl_t;

	// Weighted share in sixteenths, rounded toward minus infinity.
	function automatic err_t share(input err_t e, input logic [3:0] wt);
		logic signed [ERR_W+4:0] p;
		begin
			p = e * $signed({1'b0, wt});
			share = ERR_W'(p >>> 4);
		end
	endfunction

endpackage

[rtl/sedrgb_line_buf.sv]
// Line buffer holding the error gathered for the next row, one entry per column.
// Depends on sedrgb_pkg.
`timescale 1ns / 1ps

module sedrgb_line_buf
	import sedrgb_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [COL_W-1:0] waddr,
	input  err_line_t        wdata,
	input  logic             re,
	input  logic [COL_W-1:0] raddr,
	output err_line_t        rdata
);

	err_line_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/sedrgb_chan.sv]
// Per-channel threshold and Floyd-Steinberg error split for one pixel.
// Depends on sedrgb_pkg.
`timescale 1ns / 1ps

module sedrgb_chan
	import sedrgb_pkg::*;
(
	input  logic [PIX_W-1:0] pix,
	input  err_t             below_in,
	input  err_t             ahead_in,
	input  err_t             diag_in,
	input  err_t             pend_in,
	input  chan_ctl_t        ctl,
	output logic             dot,
	output err_t             ahead_out,
	output err_t             diag_out,
	output err_t             pend_out,
	output err_t             behind_out
);

	logic signed [ACC_W-1:0] pix_ext;
	logic signed [ACC_W-1:0] acc;
	err_t                    e;

	assign pix_ext = $signed(ACC_W'(pix) << FRAC_BITS);
	assign acc     = pix_ext + ACC_W'(below_in) + ACC_W'(ahead_in);
	assign dot     = (acc >= HALF_SCALE);
	assign e       = ERR_W'(acc - (dot ? FULL_SCALE : '0));

	assign ahead_out  = ctl.has_ahead ? share(e, W_AHEAD) : '0;
	assign pend_out   = ctl.last_row ? diag_in : err_t'(diag_in + share(e, W_BELOW));
	assign behind_out = ctl.last_row ? pend_in : err_t'(pend_in + share(e, W_BEHIND));
	assign diag_out   = (ctl.has_ahead && !ctl.last_row) ? share(e, W_DIAG) : '0;

endmodule

[rtl/serpentine_error_diffusion_rgb.sv]
// Serpentine Floyd-Steinberg halftoning of an RGB pixel stream to one bit per channel.
// Depends on sedrgb_pkg, sedrgb_line_buf, sedrgb_chan and the assertion macro header.
//
// One pixel is taken per clock while the output is not stalled. The line buffer read is
// registered with the pixel, then the threshold and error split run in one stage into the
// output register. Pixels must arrive in serpentine order (even rows left to right, odd rows
// right to left). The line buffer is not cleared after reset; the first row of each frame
// ignores it and writes every column but its last, which stays in the pending register, so
// no clearing pass is needed and a pixel can be taken from the first clock after reset.
// A register write restarts the frame and is to be made only while the block is idle.
`timescale 1ns / 1ps
`include "serpentine_error_diffusion_rgb_defines.svh"

module serpentine_error_diffusion_rgb
	import sedrgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // chan_zero, chan_one, chan_two
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // dot_zero, dot_one, dot_two, zero fill
	output logic        m_axis_tlast    // frame_done
);

	logic [LW_W-1:0]  line_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [COL_W-1:0] col_q;
	logic [FH_W-1:0]  row_q;
	logic             left_q;
	logic             first_q;

	logic [LW_W-1:0]  w_eff;
	logic [FH_W:0]    h_eff;
	logic [LW_W-1:0]  col_ext;
	logic             last_row;
	logic             has_ahead;
	logic             has_behind;
	logic [COL_W-1:0] behind;
	logic [COL_W-1:0] w_last;

	logic             in_xfer;
	logic             adv;
	logic             proc;

	logic                    v_s1;
	logic [NUM_CH*PIX_W-1:0] pix_s1;
	chan_ctl_t               ctl_s1;
	logic                    has_behind_s1;
	logic                    row_start_s1;
	logic                    row0_s1;
	logic [COL_W-1:0]        behind_s1;

	err_line_t rd_data;
	err_line_t wr_data;
	err_t      ahead_q [NUM_CH];
	err_t      diag_q  [NUM_CH];
	err_t      pend_q  [NUM_CH];
	err_t      ahead_n [NUM_CH];
	err_t      diag_n  [NUM_CH];
	err_t      pend_n  [NUM_CH];
	err_t      below_sel [NUM_CH];
	logic [NUM_CH-1:0] dot_n;

	logic              out_valid_q;
	logic [NUM_CH-1:0] dots_q;
	logic              frame_done_q;

	// Effective geometry: a zero width or height acts as one, width saturates at the buffer.
	always_comb begin
		if (line_width_q == '0) begin
			w_eff = LW_W'(1);
		end else if (line_width_q > MAX_WIDTH_V) begin
			w_eff = MAX_WIDTH_V;
		end else begin
			w_eff = line_width_q;
		end
	end

	assign h_eff      = (frame_height_q == '0) ? (FH_W+1)'(1) : {1'b0, frame_height_q};
	assign col_ext    = {1'b0, col_q};
	assign last_row   = ({1'b0, row_q} + (FH_W+1)'(1)) >= h_eff;
	assign has_ahead  = left_q ? (col_q != '0) : ((col_ext + LW_W'(1)) < w_eff);
	assign has_behind = left_q ? ((col_ext + LW_W'(1)) < w_eff) : (col_q != '0);
	assign behind     = left_q ? (col_q + COL_W'(1)) : (col_q - COL_W'(1));
	assign w_last     = COL_W'(w_eff - LW_W'(1));

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign proc          = v_s1 && adv;

	// Configuration registers and scan position; a write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LW_W'(424);
			frame_height_q <= FH_W'(636);
			col_q          <= '0;
			row_q          <= '0;
			left_q         <= 1'b0;
			first_q        <= 1'b1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_LINE_WIDTH:   line_width_q   <= cfg_wdata[LW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[FH_W-1:0];
				default:          ;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			left_q  <= 1'b0;
			first_q <= 1'b1;
		end else if (in_xfer) begin
			first_q <= !has_ahead;
			if (!has_ahead) begin
				if (last_row) begin
					row_q  <= '0;
					left_q <= 1'b0;
					col_q  <= '0;
				end else begin
					row_q  <= row_q + FH_W'(1);
					left_q <= !left_q;
					col_q  <= left_q ? '0 : w_last;
				end
			end else begin
				col_q <= left_q ? (col_q - COL_W'(1)) : (col_q + COL_W'(1));
			end
		end
	end

	// Input stage: pixel and its position flags, alongside the registered buffer read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_xfer) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1           <= s_axis_tdata;
			ctl_s1.has_ahead <= has_ahead;
			ctl_s1.last_row  <= last_row;
			has_behind_s1    <= has_behind;
			row_start_s1     <= first_q;
			row0_s1          <= (row_q == '0);
			behind_s1        <= behind;
		end
	end

	sedrgb_line_buf u_line_buf (
		.clk   (clk),
		.we    (proc && has_behind_s1),
		.waddr (behind_s1),
		.wdata (wr_data),
		.re    (in_xfer),
		.raddr (col_q),
		.rdata (rd_data)
	);

	// The column under a row's first pixel was the last one touched by the row above and
	// has not reached the buffer yet, so its error comes from the pending register.
	for (genvar i = 0; i < NUM_CH; i++) begin : g_chan
		always_comb begin
			if (row0_s1) begin
				below_sel[i] = '0;
			end else if (row_start_s1) begin
				below_sel[i] = pend_q[i];
			end else begin
				below_sel[i] = err_t'(rd_data[i*ERR_W +: ERR_W]);
			end
		end

		sedrgb_chan u_chan (
			.pix        (pix_s1[i*PIX_W +: PIX_W]),
			.below_in   (below_sel[i]),
			.ahead_in   (ahead_q[i]),
			.diag_in    (diag_q[i]),
			.pend_in    (pend_q[i]),
			.ctl        (ctl_s1),
			.dot        (dot_n[i]),
			.ahead_out  (ahead_n[i]),
			.diag_out   (diag_n[i]),
			.pend_out   (pend_n[i]),
			.behind_out (wr_data[i*ERR_W +: ERR_W])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ahead_q[i] <= '0;
				diag_q[i]  <= '0;
				pend_q[i]  <= '0;
			end else if (cfg_we) begin
				ahead_q[i] <= '0;
				diag_q[i]  <= '0;
				pend_q[i]  <= '0;
			end else if (proc) begin
				ahead_q[i] <= ahead_n[i];
				diag_q[i]  <= diag_n[i];
				pend_q[i]  <= pend_n[i];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			dots_q       <= dot_n;
			frame_done_q <= !ctl_s1.has_ahead && ctl_s1.last_row;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8-NUM_CH){1'b0}}, dots_q};
	assign m_axis_tlast  = frame_done_q;

	`SEDRGB_ASSERT(a_col_in_range, clk, arst_n, (col_ext < w_eff))
	`SEDRGB_ASSERT_IMPL(a_no_write_at_row_start, clk, arst_n, (proc && has_behind_s1), !row_start_s1)
	`SEDRGB_ASSERT(a_frame_wraps, clk, arst_n, (in_xfer && !has_ahead && last_row && !cfg_we) |=> (row_q == '0 && col_q == '0 && !left_q && first_q))
	`SEDRGB_ASSERT_IMPL(a_stage_holds, clk, arst_n, (v_s1 && !adv), !s_axis_tready)

endmodule
